@@ hw/rtl/assert_macros.svh @@
// assertion macros used by window_median_mad_outlier_reject
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/wmmo_pkg.sv @@
// types and constants of the window median / mad outlier filter
package wmmo_pkg;

  localparam int DATA_W     = 16;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int HGT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int LIM_W      = 19;

  // limit floor: 1.0 in q11.4 scaled by five
  localparam logic [LIM_W-1:0] LIM_FLOOR = 19'd80;
  localparam logic [DATA_W-1:0] SIGN_FLIP = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [DATA_W-1:0] RESET_REJECT = 16'hFFF0;
  localparam logic [HGT_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HGT_W-1:0]  RESET_HEIGHT = 11'd480;

  typedef struct packed {
    logic signed [DATA_W-1:0] pixel_value;
    logic                     drain;
  } pix_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_value;
    logic                     frame_end;
  } res_t;

  // side data riding along the median rank stage
  typedef struct packed {
    logic              border;
    logic              frame_end;
    logic [DATA_W-1:0] centre;
  } med_side_t;

  // side data riding along the mad rank stage
  typedef struct packed {
    logic              border;
    logic              frame_end;
    logic              enough;
    logic [DATA_W-1:0] centre;
    logic [DATA_W-1:0] cdev;
  } mad_side_t;

endpackage

@@ hw/rtl/wmmo_ram.sv @@
// generic simple dual-port ram with registered read
module wmmo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/wmmo_rank_sel.sv @@
// three-stage rank selection of the upper median over masked values
module wmmo_rank_sel #(
  parameter int NV = 25,
  parameter int W  = 16,
  parameter int SW = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [W-1:0]              in_vals [NV],
  input  logic [NV-1:0]             in_mask,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [W-1:0]              out_sel,
  output logic [W-1:0]              out_vals [NV],
  output logic [NV-1:0]             out_mask,
  output logic [$clog2(NV+1)-1:0]   out_count,
  output logic [SW-1:0]             out_side
);

  localparam int CNT_W = $clog2(NV+1);

  logic              a_v;
  logic [W-1:0]      a_vals [NV];
  logic [NV-1:0]     a_mask;
  logic [SW-1:0]     a_side;
  logic [NV-1:0]     a_lt [NV];

  logic              b_v;
  logic [W-1:0]      b_vals [NV];
  logic [NV-1:0]     b_mask;
  logic [SW-1:0]     b_side;
  logic [CNT_W-1:0]  b_cl [NV];
  logic [CNT_W-1:0]  b_ce [NV];
  logic [CNT_W-1:0]  b_n;

  logic [NV-1:0]     lt_next [NV];
  logic [CNT_W-1:0]  cl_next [NV];
  logic [CNT_W-1:0]  ce_next [NV];
  logic [CNT_W-1:0]  n_next;
  logic [CNT_W-1:0]  half;
  logic [W-1:0]      sel_next;

  // pairwise compares: lt[i][j] means value j sorts below value i
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        lt_next[i][j] = in_vals[j] < in_vals[i];
      end
    end
  end

  always_comb begin
    n_next = '0;
    for (int j = 0; j < NV; j++) begin
      n_next = n_next + CNT_W'(a_mask[j]);
    end
    for (int i = 0; i < NV; i++) begin
      cl_next[i] = '0;
      ce_next[i] = '0;
      for (int j = 0; j < NV; j++) begin
        cl_next[i] = cl_next[i] + CNT_W'(a_mask[j] & a_lt[i][j]);
        ce_next[i] = ce_next[i] + CNT_W'(a_mask[j] & ~a_lt[j][i]);
      end
    end
  end

  // value with at most half below it and more than half at or below it
  always_comb begin
    half     = b_n >> 1;
    sel_next = '0;
    for (int i = 0; i < NV; i++) begin
      if (b_mask[i] && (b_cl[i] <= half) && (b_ce[i] > half)) begin
        sel_next = sel_next | b_vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vals    <= in_vals;
      a_mask    <= in_mask;
      a_side    <= in_side;
      a_lt      <= lt_next;
      b_vals    <= a_vals;
      b_mask    <= a_mask;
      b_side    <= a_side;
      b_cl      <= cl_next;
      b_ce      <= ce_next;
      b_n       <= n_next;
      out_vals  <= b_vals;
      out_mask  <= b_mask;
      out_side  <= b_side;
      out_count <= b_n;
      out_sel   <= sel_next;
    end
  end

endmodule

@@ hw/rtl/window_median_mad_outlier_reject.sv @@
// Median / MAD outlier filter for a raster disparity stream. One beat is taken per clock while
// the result side does not stall; a result passes the window stages, the median selector, the
// deviation register, the MAD selector and the output register; the output lags the input by
// HALF_SIZE rows plus HALF_SIZE pixels. A row memory of MAX_WIDTH words, each holding the last
// 2*HALF_SIZE rows of one column, is read and written back once per beat and feeds a square
// window register; two three-stage rank selectors give the median and the MAD. Drain beats
// after the last pixel of a frame push out the trailing results; pixels sent then are dropped.
`include "assert_macros.svh"

module window_median_mad_outlier_reject
  import wmmo_pkg::*;
#(
  parameter int HALF_SIZE = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pix_t                 pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  localparam int WIN   = 2 * HALF_SIZE + 1;
  localparam int NV    = WIN * WIN;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int WORD  = (WIN - 1) * DATA_W;
  localparam int CNT_W = $clog2(NV + 1);

  logic [DATA_W-1:0] reject_code;
  logic [HGT_W-1:0]  frame_width;
  logic [HGT_W-1:0]  frame_height;

  logic [COL_W-1:0] in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_column, out_column_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0] fl_col, fl_col_next;
  logic [WID_W-1:0] cur_w, cur_w_next;
  logic [HGT_W-1:0] cur_h, cur_h_next;
  logic             flushing, flushing_next;

  logic             en, accept, do_shift, do_emit, fe, border;
  logic [COL_W-1:0] col_sel;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  logic              s1_v, s1_emit, s1_border, s1_fe;
  logic [DATA_W-1:0] s1_pix;
  logic [COL_W-1:0]  s1_addr;
  logic [WORD-1:0]   ram_rdata, ram_wdata;

  logic [DATA_W-1:0] win [WIN][WIN];
  logic              s2_v, s2_border, s2_fe;

  logic [DATA_W-1:0] m_vals [NV];
  logic [NV-1:0]     m_mask;
  med_side_t         m_side;
  logic              r1_v;
  logic [DATA_W-1:0] r1_sel;
  logic [DATA_W-1:0] r1_vals [NV];
  logic [NV-1:0]     r1_mask;
  logic [CNT_W-1:0]  r1_n;
  med_side_t         r1_side;

  logic              d_v;
  logic [DATA_W-1:0] d_vals [NV];
  logic [NV-1:0]     d_mask;
  mad_side_t         d_side;
  logic [DATA_W-1:0] dev_next [NV];
  logic [DATA_W-1:0] cflip;
  mad_side_t         d_side_next;

  logic              r2_v;
  logic [DATA_W-1:0] r2_sel;
  logic [DATA_W-1:0] r2_vals [NV];
  logic [NV-1:0]     r2_mask;
  logic [CNT_W-1:0]  r2_n;
  mad_side_t         r2_side;

  logic [LIM_W-1:0]  lim, score;
  logic              reject;

  assign cfg_ready = 1'b1;
  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;
  assign accept    = pix_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_code  <= RESET_REJECT;
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REJECT_CODE:  reject_code  <= cfg_data;
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[HGT_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // position of the output pixel within the latched frame
  assign fe = (int'(out_row) + 1 == int'(cur_h)) && (int'(out_column) + 1 == int'(cur_w));
  assign border = (int'(out_row) < HALF_SIZE) || (int'(out_row) + HALF_SIZE >= int'(cur_h)) ||
                  (int'(out_column) < HALF_SIZE) ||
                  (int'(out_column) + HALF_SIZE >= int'(cur_w));

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    fl_col_next     = fl_col;
    cur_w_next      = cur_w;
    cur_h_next      = cur_h;
    flushing_next   = flushing;
    do_shift        = 1'b0;
    do_emit         = 1'b0;
    col_sel         = in_column;
    w_eff           = cur_w;
    h_eff           = cur_h;
    if (accept) begin
      if (flushing) begin
        do_shift = 1'b1;
        do_emit  = 1'b1;
        col_sel  = fl_col;
        if (int'(fl_col) + 1 >= int'(cur_w)) begin
          fl_col_next = '0;
        end else begin
          fl_col_next = fl_col + COL_W'(1);
        end
      end else if (!pix.drain) begin
        // frame size is latched on the first pixel of a frame
        if (in_row == '0 && in_column == '0) begin
          if (int'(frame_width) < WIN) begin
            w_eff = WID_W'(WIN);
          end else if (int'(frame_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
          end else begin
            w_eff = WID_W'(frame_width);
          end
          if (int'(frame_height) < WIN) begin
            h_eff = HGT_W'(WIN);
          end else if (int'(frame_height) > MAX_HEIGHT) begin
            h_eff = HGT_W'(MAX_HEIGHT);
          end else begin
            h_eff = frame_height;
          end
          cur_w_next = w_eff;
          cur_h_next = h_eff;
        end
        do_shift = 1'b1;
        do_emit  = (int'(in_row) > HALF_SIZE) ||
                   ((int'(in_row) == HALF_SIZE) && (int'(in_column) >= HALF_SIZE));
        if (int'(in_column) + 1 >= int'(w_eff)) begin
          in_column_next = '0;
          if (int'(in_row) + 1 >= int'(h_eff)) begin
            in_row_next   = '0;
            flushing_next = 1'b1;
            fl_col_next   = '0;
          end else begin
            in_row_next = in_row + ROW_W'(1);
          end
        end else begin
          in_column_next = in_column + COL_W'(1);
        end
      end
      if (do_emit) begin
        if (fe) begin
          out_column_next = '0;
          out_row_next    = '0;
          flushing_next   = 1'b0;
        end else if (int'(out_column) + 1 >= int'(cur_w)) begin
          out_column_next = '0;
          out_row_next    = out_row + ROW_W'(1);
        end else begin
          out_column_next = out_column + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      fl_col     <= '0;
      cur_w      <= '0;
      cur_h      <= '0;
      flushing   <= 1'b0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      fl_col     <= fl_col_next;
      cur_w      <= cur_w_next;
      cur_h      <= cur_h_next;
      flushing   <= flushing_next;
    end
  end

  // row memory: one word per column, oldest row in the low slot
  wmmo_ram #(
    .WIDTH(WORD),
    .DEPTH(MAX_WIDTH)
  ) u_rows (
    .clk  (clk),
    .we   (s1_v && en),
    .waddr(s1_addr),
    .wdata(ram_wdata),
    .re   (accept && do_shift),
    .raddr(col_sel),
    .rdata(ram_rdata)
  );

  always_comb begin
    for (int r = 0; r < WIN - 1; r++) begin
      if (r < WIN - 2) begin
        ram_wdata[r*DATA_W +: DATA_W] = ram_rdata[(r+1)*DATA_W +: DATA_W];
      end else begin
        ram_wdata[r*DATA_W +: DATA_W] = s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= accept && do_shift;
      s2_v <= s1_v && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit   <= do_emit;
      s1_border <= border;
      s1_fe     <= fe;
      s1_pix    <= pix.pixel_value;
      s1_addr   <= col_sel;
      s2_border <= s1_border;
      s2_fe     <= s1_fe;
      if (s1_v) begin
        for (int c = 0; c < WIN; c++) begin
          for (int r = 0; r < WIN; r++) begin
            if (c < WIN - 1) begin
              win[c][r] <= win[c+1][r];
            end else if (r < WIN - 1) begin
              win[c][r] <= ram_rdata[r*DATA_W +: DATA_W];
            end else begin
              win[c][r] <= s1_pix;
            end
          end
        end
      end
    end
  end

  // sign bit flipped so that unsigned order matches signed order
  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      for (int r = 0; r < WIN; r++) begin
        m_vals[c*WIN + r] = win[c][r] ^ SIGN_FLIP;
        m_mask[c*WIN + r] = win[c][r] != reject_code;
      end
    end
    m_side.border    = s2_border;
    m_side.frame_end = s2_fe;
    m_side.centre    = win[HALF_SIZE][HALF_SIZE];
  end

  wmmo_rank_sel #(
    .NV(NV),
    .W (DATA_W),
    .SW($bits(med_side_t))
  ) u_median (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_v),
    .in_vals  (m_vals),
    .in_mask  (m_mask),
    .in_side  (m_side),
    .out_valid(r1_v),
    .out_sel  (r1_sel),
    .out_vals (r1_vals),
    .out_mask (r1_mask),
    .out_count(r1_n),
    .out_side (r1_side)
  );

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      if (r1_vals[i] >= r1_sel) begin
        dev_next[i] = r1_vals[i] - r1_sel;
      end else begin
        dev_next[i] = r1_sel - r1_vals[i];
      end
    end
    cflip                 = r1_side.centre ^ SIGN_FLIP;
    d_side_next.border    = r1_side.border;
    d_side_next.frame_end = r1_side.frame_end;
    d_side_next.enough    = int'(r1_n) > 2;
    d_side_next.centre    = r1_side.centre;
    d_side_next.cdev      = (cflip >= r1_sel) ? (cflip - r1_sel) : (r1_sel - cflip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_vals <= dev_next;
      d_mask <= r1_mask;
      d_side <= d_side_next;
    end
  end

  wmmo_rank_sel #(
    .NV(NV),
    .W (DATA_W),
    .SW($bits(mad_side_t))
  ) u_mad (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .in_vals  (d_vals),
    .in_mask  (d_mask),
    .in_side  (d_side),
    .out_valid(r2_v),
    .out_sel  (r2_sel),
    .out_vals (r2_vals),
    .out_mask (r2_mask),
    .out_count(r2_n),
    .out_side (r2_side)
  );

  // 5*dev against max(8*mad, floor)
  always_comb begin
    lim = {r2_sel, 3'b000};
    if (lim < LIM_FLOOR) begin
      lim = LIM_FLOOR;
    end
    score  = {r2_side.cdev, 2'b00} + LIM_W'(r2_side.cdev);
    reject = !r2_side.border && r2_side.enough && (score > lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= r2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.filtered_value <= reject ? reject_code : r2_side.centre;
      res.frame_end      <= r2_side.frame_end;
    end
  end

  `ASSERT_IMP(a_flush_idle, clk, rst, flushing, (in_column == '0) && (in_row == '0), "input counters moved while flushing")
  `ASSERT_IMP(a_ram_rmw, clk, rst, accept && do_shift && s1_v && en, col_sel != s1_addr, "row memory read hits column being written back")
  `ASSERT_NXT(a_out_col, clk, rst, cur_w != '0, out_column < cur_w, "output column beyond frame width")

endmodule
